// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL of the stepped duty regulator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, held off while the synchronous reset is asserted.
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition in one cycle implies the property in the next, held off in reset.
`define ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== rtl/acsdr_pkg.sv =====
// ----------------------------------------------------------------------------
// acsdr_pkg
// Shared widths, register codes, reset values and step sizes for the
// stepped duty regulator.
// ----------------------------------------------------------------------------
package acsdr_pkg;

    localparam int MV_W       = 20;   // millivolt quantities
    localparam int CMP_W      = 16;   // PWM compare values
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 20;
    localparam int STEP_W     = 3;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_NOMINAL      = 3'd0,
        CFG_OVERVOLTAGE  = 3'd1,
        CFG_HIGH_MIN     = 3'd2,
        CFG_HIGH_MAX     = 3'd3,
        CFG_LOW_MIN      = 3'd4,
        CFG_LOW_MAX      = 3'd5,
        CFG_LARGE_ERROR  = 3'd6,
        CFG_MEDIUM_ERROR = 3'd7
    } t_cfg_reg;

    // Reset values of the configuration registers
    localparam logic [MV_W-1:0]  RST_NOMINAL      = 20'd2000;
    localparam logic [MV_W-1:0]  RST_OVERVOLTAGE  = 20'd2500;
    localparam logic [CMP_W-1:0] RST_HIGH_MIN     = 16'd0;
    localparam logic [CMP_W-1:0] RST_HIGH_MAX     = 16'd1000;
    localparam logic [CMP_W-1:0] RST_LOW_MIN      = 16'd0;
    localparam logic [CMP_W-1:0] RST_LOW_MAX      = 16'd1000;
    localparam logic [MV_W-1:0]  RST_LARGE_ERROR  = 20'd200;
    localparam logic [MV_W-1:0]  RST_MEDIUM_ERROR = 20'd50;

    // Compare step sizes
    localparam logic [STEP_W-1:0] STEP_NONE   = 3'd0;
    localparam logic [STEP_W-1:0] STEP_SMALL  = 3'd1;
    localparam logic [STEP_W-1:0] STEP_MEDIUM = 3'd2;
    localparam logic [STEP_W-1:0] STEP_LARGE  = 3'd5;

endpackage

// ===== rtl/ac_stepped_duty_regulator_core.sv =====
// ----------------------------------------------------------------------------
// ac_stepped_duty_regulator_core
// Steps the high-side or low-side PWM compare value towards the nominal
// output voltage, one measurement at a time.
// ----------------------------------------------------------------------------
// Usage:
//  - Slave stream: one measurement per transfer, tdata = measured voltage in
//    mV, tuser = booster select (0 high-side stage, 1 low-side stage).
//  - Master stream: one compare write per measurement: tdata holds the write
//    enable and the compare value, tuser the stage it belongs to.
//  - Configuration: write enable, 3-bit register index and 20-bit data; write
//    only while no measurement is in flight.
//  - Path: an input transfer is held in the input register, then its result in
//    the result register, from which it is offered on the master side.
//  - Throughput: one measurement per cycle while the master does not stall. The stored compare values are
//    updated in the same cycle the result register is loaded, so the
//    following measurement always sees the updated value.
//  - A stalled master holds its result; one further measurement is still
//    taken into the input register, after which the slave side stalls too.
//  - Reset (synchronous, active low) empties both registers, clears the two
//    stored compare values and loads the configuration defaults.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ac_stepped_duty_regulator_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // measurement stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [acsdr_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [19:0] measured_mv
    input  logic                            s_axis_tuser,  // [0] booster_select
    // compare write stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [acsdr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // [0] write_enable,
                                                             // [16:1] compare_value
    output logic                            m_axis_tuser,  // [0] stage_select
    // configuration
    input  logic                            i_cfg_we,
    input  logic [acsdr_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [acsdr_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import acsdr_pkg::*;

    // configuration registers
    logic [MV_W-1:0]  r_nominal, r_overvoltage, r_large_err, r_medium_err;
    logic [CMP_W-1:0] r_high_min, r_high_max, r_low_min, r_low_max;

    // stored compare values
    logic [CMP_W-1:0] r_high_cmp, r_low_cmp;

    // input register
    logic             r_in_valid;
    logic [MV_W-1:0]  r_in_mv;
    logic             r_in_sel;

    // result register
    logic             r_out_valid;
    logic             r_out_we;
    logic             r_out_sel;
    logic [CMP_W-1:0] r_out_cv;

    // handshake
    logic w_out_free, w_advance, w_in_take;

    // datapath
    logic [CMP_W-1:0]  w_cur, w_min, w_max;
    logic              w_above, w_below, w_ov;
    logic [MV_W-1:0]   w_err;
    logic [STEP_W-1:0] w_max_step, w_dn_step, w_up_step;
    logic [CMP_W:0]    w_cur_x, w_min_x, w_max_x;
    logic              n_we;
    logic [CMP_W-1:0]  n_cv, n_val;

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_advance     = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_out_free;
    assign w_in_take     = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_sel;
    assign m_axis_tdata  = {(OUT_TDATA_W - CMP_W - 1)'(0), r_out_cv, r_out_we};

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nominal     <= RST_NOMINAL;
            r_overvoltage <= RST_OVERVOLTAGE;
            r_high_min    <= RST_HIGH_MIN;
            r_high_max    <= RST_HIGH_MAX;
            r_low_min     <= RST_LOW_MIN;
            r_low_max     <= RST_LOW_MAX;
            r_large_err   <= RST_LARGE_ERROR;
            r_medium_err  <= RST_MEDIUM_ERROR;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_addr))
                CFG_NOMINAL:      r_nominal     <= i_cfg_wdata[MV_W-1:0];
                CFG_OVERVOLTAGE:  r_overvoltage <= i_cfg_wdata[MV_W-1:0];
                CFG_HIGH_MIN:     r_high_min    <= i_cfg_wdata[CMP_W-1:0];
                CFG_HIGH_MAX:     r_high_max    <= i_cfg_wdata[CMP_W-1:0];
                CFG_LOW_MIN:      r_low_min     <= i_cfg_wdata[CMP_W-1:0];
                CFG_LOW_MAX:      r_low_max     <= i_cfg_wdata[CMP_W-1:0];
                CFG_LARGE_ERROR:  r_large_err   <= i_cfg_wdata[MV_W-1:0];
                CFG_MEDIUM_ERROR: r_medium_err  <= i_cfg_wdata[MV_W-1:0];
                default: ;
            endcase
        end
    end

    // stage operands and error magnitude
    always_comb begin
        w_cur   = r_in_sel ? r_low_cmp : r_high_cmp;
        w_min   = r_in_sel ? r_low_min : r_high_min;
        w_max   = r_in_sel ? r_low_max : r_high_max;
        w_above = r_in_mv > r_nominal;
        w_below = r_in_mv < r_nominal;
        w_ov    = w_above && (r_in_mv > r_overvoltage);
        w_err   = w_above ? (r_in_mv - r_nominal) : (r_nominal - r_in_mv);
        w_cur_x = {1'b0, w_cur};
        w_min_x = {1'b0, w_min};
        w_max_x = {1'b0, w_max};
    end

    // largest step permitted by the error (high side always steps by one)
    always_comb begin
        if (!r_in_sel) begin
            w_max_step = STEP_SMALL;
        end else if (w_err > r_large_err) begin
            w_max_step = STEP_LARGE;
        end else if (w_err > r_medium_err) begin
            w_max_step = STEP_MEDIUM;
        end else begin
            w_max_step = STEP_NONE;
        end
    end

    // largest step that keeps the value inside its limit, per direction
    always_comb begin
        if (w_max_step >= STEP_LARGE && w_cur_x >= w_min_x + (CMP_W+1)'(STEP_LARGE)) begin
            w_dn_step = STEP_LARGE;
        end else if (w_max_step >= STEP_MEDIUM
                     && w_cur_x >= w_min_x + (CMP_W+1)'(STEP_MEDIUM)) begin
            w_dn_step = STEP_MEDIUM;
        end else if (w_max_step >= STEP_SMALL
                     && w_cur_x >= w_min_x + (CMP_W+1)'(STEP_SMALL)) begin
            w_dn_step = STEP_SMALL;
        end else begin
            w_dn_step = STEP_NONE;
        end

        if (w_max_step >= STEP_LARGE && w_cur_x + (CMP_W+1)'(STEP_LARGE) <= w_max_x) begin
            w_up_step = STEP_LARGE;
        end else if (w_max_step >= STEP_MEDIUM
                     && w_cur_x + (CMP_W+1)'(STEP_MEDIUM) <= w_max_x) begin
            w_up_step = STEP_MEDIUM;
        end else if (w_max_step >= STEP_SMALL
                     && w_cur_x + (CMP_W+1)'(STEP_SMALL) <= w_max_x) begin
            w_up_step = STEP_SMALL;
        end else begin
            w_up_step = STEP_NONE;
        end
    end

    // compare write and next stored value
    always_comb begin
        n_we  = 1'b0;
        n_cv  = w_cur;
        n_val = w_cur;
        if (w_above) begin
            if (w_ov) begin
                // overvoltage: force the minimum, keep the stored value
                n_we = 1'b1;
                n_cv = w_min;
            end else if (w_dn_step != STEP_NONE) begin
                n_val = w_cur - CMP_W'(w_dn_step);
                n_we  = 1'b1;
                n_cv  = n_val;
            end
        end else if (w_below) begin
            if (w_up_step != STEP_NONE) begin
                n_val = w_cur + CMP_W'(w_up_step);
                n_we  = 1'b1;
                n_cv  = n_val;
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
        if (w_in_take) begin
            r_in_mv  <= s_axis_tdata[MV_W-1:0];
            r_in_sel <= s_axis_tuser;
        end
    end

    // stored compare values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_cmp <= '0;
            r_low_cmp  <= '0;
        end else if (w_advance) begin
            if (r_in_sel) begin
                r_low_cmp <= n_val;
            end else begin
                r_high_cmp <= n_val;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
        if (w_advance) begin
            r_out_we  <= n_we;
            r_out_sel <= r_in_sel;
            r_out_cv  <= n_cv;
        end
    end

    // checks
    `ASSERT_CLKD(a_high_tracks_write, i_clk, i_rst_n,
        w_advance && !r_in_sel && n_we && !w_ov |=> r_high_cmp == r_out_cv,
        "high-side stored value differs from the value written")
    `ASSERT_CLKD(a_low_tracks_write, i_clk, i_rst_n,
        w_advance && r_in_sel && n_we && !w_ov |=> r_low_cmp == r_out_cv,
        "low-side stored value differs from the value written")
    `ASSERT_CLKD(a_other_stage_kept, i_clk, i_rst_n,
        w_advance && r_in_sel |=> $stable(r_high_cmp),
        "high-side value changed on a low-side measurement")
    `ASSERT_CLKD(a_no_write_shows_stored, i_clk, i_rst_n,
        w_advance && !n_we |=> r_out_cv == (r_out_sel ? r_low_cmp : r_high_cmp),
        "result without write does not show the stored value")
    `ASSERT_NEXT(a_result_held, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
        "stalled result changed before its transfer")

endmodule

// ===== tb/ac_stepped_duty_regulator_core_test.sv =====
// ----------------------------------------------------------------------------
// ac_stepped_duty_regulator_core_test
// Self-checking bench for the stepped duty regulator core. Measurements are
// streamed in with random gaps while the result side stalls at random. Every
// accepted measurement is run through a local model of the two stored compare
// values, and each returned compare write is checked field by field against
// the oldest prediction. Register settings are changed between phases while
// the core is idle, including extreme and inconsistent settings.
// ----------------------------------------------------------------------------
module ac_stepped_duty_regulator_core_test;

    import acsdr_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 150;
    localparam logic [MV_W-1:0]  MV_MAX  = '1;
    localparam logic [CMP_W-1:0] CMP_MAX = '1;

    // One compare write as returned on the master side
    typedef struct packed {
        logic             write_en;
        logic             stage;
        logic [CMP_W-1:0] value;
    } t_compare_write;

    typedef logic [CFG_DATA_W-1:0] t_reg_bank [8];

    // Clock, reset and block ports
    logic                   i_clk   = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;  // [19:0] measured_mv
    logic                   s_axis_tuser  = 1'b0; // [0] booster_select
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [0] write_enable, [16:1] compare_value
    logic                   m_axis_tuser;        // [0] stage_select
    logic                   i_cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata = '0;

    // Model state: register copy and the two stored compare values
    t_reg_bank        reg_model;
    logic [CMP_W-1:0] high_cmp;
    logic [CMP_W-1:0] low_cmp;

    t_compare_write pending_writes [$];
    t_compare_write due;

    // Run control and bookkeeping
    bit tx_no_idle = 1'b0;
    bit rx_no_idle = 1'b0;
    int unsigned rx_hold_cycles = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned fail_count     = 0;
    int unsigned items_sent     = 0;
    int unsigned results_seen   = 0;
    int unsigned writes_seen    = 0;
    int unsigned settings_count = 0;

    ac_stepped_duty_regulator_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Regulator model
    // ------------------------------------------------------------------
    function automatic bit is_compare_reg(t_cfg_reg r);
        return r inside {CFG_HIGH_MIN, CFG_HIGH_MAX, CFG_LOW_MIN, CFG_LOW_MAX};
    endfunction

    function automatic void reset_model();
        reg_model[CFG_NOMINAL]      = RST_NOMINAL;
        reg_model[CFG_OVERVOLTAGE]  = RST_OVERVOLTAGE;
        reg_model[CFG_HIGH_MIN]     = CFG_DATA_W'(RST_HIGH_MIN);
        reg_model[CFG_HIGH_MAX]     = CFG_DATA_W'(RST_HIGH_MAX);
        reg_model[CFG_LOW_MIN]      = CFG_DATA_W'(RST_LOW_MIN);
        reg_model[CFG_LOW_MAX]      = CFG_DATA_W'(RST_LOW_MAX);
        reg_model[CFG_LARGE_ERROR]  = RST_LARGE_ERROR;
        reg_model[CFG_MEDIUM_ERROR] = RST_MEDIUM_ERROR;
        high_cmp = '0;
        low_cmp  = '0;
    endfunction

    // Largest stride not above the ceiling that keeps the value within the limit
    function automatic logic [31:0] allowed_stride(logic [31:0] v, logic [31:0] lim,
                                                   logic [31:0] ceiling, bit down);
        logic [31:0] cand [3];
        cand = '{32'(STEP_LARGE), 32'(STEP_MEDIUM), 32'(STEP_SMALL)};
        foreach (cand[i]) begin
            if (cand[i] <= ceiling) begin
                if (down ? (v >= lim + cand[i]) : (v + cand[i] <= lim))
                    return cand[i];
            end
        end
        return 32'(STEP_NONE);
    endfunction

    // Applies one measurement to the model and returns the compare write it causes
    function automatic t_compare_write regulate(logic [MV_W-1:0] mv, logic sel);
        t_compare_write w;
        logic [31:0] meas, v, lo, hi, nom, ov, err, ceiling, stride;
        meas = 32'(mv);
        v    = sel ? 32'(low_cmp) : 32'(high_cmp);
        lo   = sel ? 32'(reg_model[CFG_LOW_MIN]) : 32'(reg_model[CFG_HIGH_MIN]);
        hi   = sel ? 32'(reg_model[CFG_LOW_MAX]) : 32'(reg_model[CFG_HIGH_MAX]);
        nom  = 32'(reg_model[CFG_NOMINAL]);
        ov   = 32'(reg_model[CFG_OVERVOLTAGE]);
        err  = (meas > nom) ? meas - nom : nom - meas;

        // high-side stage always steps by one; low-side picks by error size
        ceiling = 32'(STEP_SMALL);
        if (sel) begin
            if (err > 32'(reg_model[CFG_LARGE_ERROR]))
                ceiling = 32'(STEP_LARGE);
            else if (err > 32'(reg_model[CFG_MEDIUM_ERROR]))
                ceiling = 32'(STEP_MEDIUM);
            else
                ceiling = 32'(STEP_NONE);
        end

        w.write_en = 1'b0;
        w.stage    = sel;
        w.value    = v[CMP_W-1:0];
        if (meas > nom) begin
            if (meas > ov) begin
                // overvoltage: force the minimum, keep the stored value
                w.write_en = 1'b1;
                w.value    = lo[CMP_W-1:0];
            end else if (v > lo) begin
                stride = allowed_stride(v, lo, ceiling, 1'b1);
                if (stride != 0) begin
                    v = v - stride;
                    w.write_en = 1'b1;
                    w.value    = v[CMP_W-1:0];
                end
            end
        end else if (meas < nom) begin
            if (v < hi) begin
                stride = allowed_stride(v, hi, ceiling, 1'b0);
                if (stride != 0) begin
                    v = v + stride;
                    w.write_en = 1'b1;
                    w.value    = v[CMP_W-1:0];
                end
            end
        end

        if (sel)
            low_cmp = v[CMP_W-1:0];
        else
            high_cmp = v[CMP_W-1:0];
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_reg_bank make_bank(logic [MV_W-1:0] nom, logic [MV_W-1:0] ov,
                                            logic [CMP_W-1:0] hmin, logic [CMP_W-1:0] hmax,
                                            logic [CMP_W-1:0] lmin, logic [CMP_W-1:0] lmax,
                                            logic [MV_W-1:0] large_err,
                                            logic [MV_W-1:0] medium_err);
        t_reg_bank b;
        b[CFG_NOMINAL]      = nom;
        b[CFG_OVERVOLTAGE]  = ov;
        b[CFG_HIGH_MIN]     = 20'(hmin);
        b[CFG_HIGH_MAX]     = 20'(hmax);
        b[CFG_LOW_MIN]      = 20'(lmin);
        b[CFG_LOW_MAX]      = 20'(lmax);
        b[CFG_LARGE_ERROR]  = large_err;
        b[CFG_MEDIUM_ERROR] = medium_err;
        return b;
    endfunction

    // Mostly narrow compare windows so the limits are hit often
    function automatic t_reg_bank random_bank();
        t_reg_bank b;
        logic [31:0] nom, ov, lo, hi;
        nom = ($urandom_range(0, 7) == 0) ? 32'($urandom) & 32'hFFFFF
                                          : 32'($urandom_range(500, 5000));
        ov  = ($urandom_range(0, 7) == 0) ? 32'($urandom) & 32'hFFFFF
                                          : nom + $urandom_range(0, 800);
        if (ov > 32'hFFFFF)
            ov = 32'hFFFFF;
        b[CFG_NOMINAL]     = nom[MV_W-1:0];
        b[CFG_OVERVOLTAGE] = ov[MV_W-1:0];
        for (int s = 0; s < 2; s++) begin
            if ($urandom_range(0, 9) == 0) begin
                lo = $urandom_range(0, 65535);
                hi = $urandom_range(0, 65535);
            end else begin
                lo = $urandom_range(0, 30);
                hi = lo + $urandom_range(0, 60);
                if ($urandom_range(0, 7) == 0) begin
                    // minimum above maximum
                    hi = lo;
                    lo = lo + $urandom_range(1, 20);
                end
            end
            // upper data bits are don't-care for compare registers
            b[s ? CFG_LOW_MIN : CFG_HIGH_MIN] = {4'($urandom), lo[CMP_W-1:0]};
            b[s ? CFG_LOW_MAX : CFG_HIGH_MAX] = {4'($urandom), hi[CMP_W-1:0]};
        end
        b[CFG_LARGE_ERROR]  = 20'($urandom_range(0, 400));
        b[CFG_MEDIUM_ERROR] = 20'($urandom_range(0, 200));
        return b;
    endfunction

    // Measurement around the current thresholds, with some full-range noise
    function automatic logic [MV_W-1:0] pick_measurement();
        logic [31:0] nom, off, v;
        int unsigned dice;
        bit up;
        nom  = 32'(reg_model[CFG_NOMINAL]);
        up   = 1'($urandom_range(0, 1));
        dice = $urandom_range(0, 99);
        off  = 0;
        if (dice < 8)
            return nom[MV_W-1:0];
        else if (dice < 30)
            off = $urandom_range(0, reg_model[CFG_MEDIUM_ERROR]);
        else if (dice < 55)
            off = 32'(reg_model[CFG_MEDIUM_ERROR]) + $urandom_range(1, 150);
        else if (dice < 75)
            off = 32'(reg_model[CFG_LARGE_ERROR]) + $urandom_range(1, 300);
        else if (dice < 85) begin
            v = 32'(reg_model[CFG_OVERVOLTAGE]) + $urandom_range(1, 200);
            return (v > 32'hFFFFF) ? MV_MAX : v[MV_W-1:0];
        end else if (dice < 95)
            return MV_W'($urandom);
        else
            return up ? MV_MAX : '0;
        v = up ? nom + off : ((nom >= off) ? nom - off : 32'd0);
        return (v > 32'hFFFFF) ? MV_MAX : v[MV_W-1:0];
    endfunction

    // Waits until every predicted compare write has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_writes.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes every register while the core is idle
    task automatic apply_settings(input t_reg_bank bank);
        t_cfg_reg r;
        drain();
        r = r.first();
        do begin
            i_cfg_we    <= 1'b1;
            i_cfg_addr  <= r;
            i_cfg_wdata <= bank[r];
            @(posedge i_clk);
            reg_model[r] = is_compare_reg(r) ? (bank[r] & 20'h0FFFF) : bank[r];
            r = r.next();
        end while (r != r.first());
        i_cfg_we <= 1'b0;
        settings_count++;
    endtask

    // Offers one measurement and predicts its result once it is transferred
    task automatic send_measurement(input logic [MV_W-1:0] mv, input logic sel);
        int unsigned gap;
        gap = tx_no_idle ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W-MV_W){1'b0}}, mv};
        s_axis_tuser  <= sel;
        do
            @(posedge i_clk);
        while (s_axis_tready !== 1'b1);
        pending_writes.push_back(regulate(mv, sel));
        items_sent++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset values: equal, deadband, medium and large errors, overvoltage
    task automatic test_reset_defaults();
        send_measurement(20'd2000, 1'b0);
        send_measurement(20'd2000, 1'b1);
        send_measurement(20'd1999, 1'b0);
        send_measurement(20'd1990, 1'b1);
        send_measurement(20'd1950, 1'b1);
        send_measurement(20'd1949, 1'b1);
        send_measurement(20'd1800, 1'b1);
        send_measurement(20'd1799, 1'b1);
        send_measurement(20'd0,    1'b1);
        send_measurement(20'd0,    1'b0);
        send_measurement(20'd2300, 1'b1);
        send_measurement(20'd2100, 1'b1);
        send_measurement(20'd2030, 1'b1);
        send_measurement(20'd2001, 1'b0);
        send_measurement(20'd2500, 1'b0);
        send_measurement(20'd2500, 1'b0);
        send_measurement(20'd2501, 1'b0);
        send_measurement(MV_MAX,   1'b1);
        send_measurement(20'd2200, 1'b1);
        send_measurement(20'd2400, 1'b1);
        send_measurement(20'd2400, 1'b1);
    endtask

    // Narrow windows: strides shrink at the limits, values outside the window
    task automatic test_compare_limits();
        apply_settings(make_bank(20'd1000, 20'd1500, 16'd3, 16'd6, 16'd2, 16'd8,
                                 20'd100, 20'd10));
        repeat (7) send_measurement(20'd900, 1'b0);
        repeat (4) send_measurement(20'd0, 1'b1);
        repeat (3) send_measurement(20'd1400, 1'b1);
        repeat (2) send_measurement(20'd1001, 1'b0);
        // stored values now below the new minimum
        apply_settings(make_bank(20'd1000, 20'd1500, 16'd20, 16'd30, 16'd20, 16'd30,
                                 20'd100, 20'd10));
        send_measurement(20'd1400, 1'b1);
        send_measurement(20'd1200, 1'b0);
        send_measurement(20'd800,  1'b1);
        send_measurement(20'd950,  1'b1);
        send_measurement(20'd999,  1'b0);
    endtask

    // Minimum above maximum, overvoltage below nominal, swapped thresholds,
    // all-zero and all-ones registers
    task automatic test_register_extremes();
        apply_settings(make_bank(20'd1000, 20'd500, 16'd40, 16'd10, 16'd50, 16'd10,
                                 20'd10, 20'd100));
        send_measurement(20'd700,  1'b0);
        send_measurement(20'd1001, 1'b0);
        send_measurement(20'd900,  1'b1);
        send_measurement(20'd950,  1'b1);
        send_measurement(20'd995,  1'b1);
        send_measurement(20'd1100, 1'b1);
        repeat (6) send_measurement(pick_measurement(), 1'($urandom_range(0, 1)));

        apply_settings(make_bank('0, '0, '0, '0, '0, '0, '0, '0));
        send_measurement(20'd0, 1'b0);
        send_measurement(20'd0, 1'b1);
        send_measurement(20'd1, 1'b0);
        send_measurement(20'd5, 1'b1);
        send_measurement(MV_MAX, 1'b0);
        send_measurement(MV_MAX, 1'b1);

        apply_settings(make_bank(MV_MAX, MV_MAX, CMP_MAX, CMP_MAX, CMP_MAX, CMP_MAX,
                                 MV_MAX, MV_MAX));
        send_measurement(20'd0,  1'b0);
        send_measurement(20'd0,  1'b1);
        send_measurement(MV_MAX, 1'b0);
        send_measurement(MV_MAX, 1'b1);

        // every error above the thresholds: low-side strides of five
        apply_settings(make_bank(MV_MAX, MV_MAX, '0, CMP_MAX, '0, CMP_MAX, '0, '0));
        repeat (4) send_measurement(20'd0, 1'b1);
        send_measurement(20'h7FFFF, 1'b0);
    endtask

    // Random settings, random measurements; one phase runs without gaps
    task automatic test_random_regulation();
        for (int phase = 0; phase < 8; phase++) begin
            apply_settings(random_bank());
            tx_no_idle = (phase == 3);
            rx_no_idle = (phase == 3);
            repeat (100) send_measurement(pick_measurement(), 1'($urandom_range(0, 1)));
        end
        tx_no_idle = 1'b0;
        rx_no_idle = 1'b0;
    endtask

    // Long receiver stall while the sender keeps offering, then a full pause
    task automatic test_back_pressure();
        apply_settings(random_bank());
        tx_no_idle     = 1'b1;
        rx_hold_cycles = HOLD_CYCLES;
        repeat (40) send_measurement(pick_measurement(), 1'($urandom_range(0, 1)));
        tx_no_idle = 1'b0;
        repeat (20) send_measurement(pick_measurement(), 1'($urandom_range(0, 1)));
        drain();
        repeat (20) send_measurement(pick_measurement(), 1'($urandom_range(0, 1)));
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls, plus the long hold when requested
    // ------------------------------------------------------------------
    initial begin
        int unsigned stall;
        wait (i_rst_n === 1'b1);
        forever begin
            if (rx_hold_cycles != 0) begin
                stall = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else begin
                stall = rx_no_idle ? 0 : $urandom_range(0, 9);
            end
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge i_clk);
            while (m_axis_tvalid !== 1'b1);
        end
    end

    // Check each result transfer against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (pending_writes.size() == 0) begin
                fail_count++;
                $display("%0t: result with nothing expected: we=%0b stage=%0b value=%0d",
                         $time, m_axis_tdata[0], m_axis_tuser, m_axis_tdata[16:1]);
            end else begin
                due = pending_writes.pop_front();
                if (due.write_en)
                    writes_seen++;
                if (m_axis_tdata[0] !== due.write_en) begin
                    fail_count++;
                    $display("%0t: write_enable expected %0b actual %0b",
                             $time, due.write_en, m_axis_tdata[0]);
                end
                if (m_axis_tuser !== due.stage) begin
                    fail_count++;
                    $display("%0t: stage_select expected %0b actual %0b",
                             $time, due.stage, m_axis_tuser);
                end
                if (m_axis_tdata[16:1] !== due.value) begin
                    fail_count++;
                    $display("%0t: compare_value expected %0d actual %0d",
                             $time, due.value, m_axis_tdata[16:1]);
                end
            end
        end
    end

    // Watchdog: too long without any transfer or register write
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (s_axis_tvalid && s_axis_tready)
                || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        reset_model();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_compare_limits();
        test_register_extremes();
        test_random_regulation();
        test_back_pressure();

        drain();
        repeat (8) @(posedge i_clk);
        $display("Run covered %0d measurements under %0d register settings.",
                 items_sent, settings_count);
        $display("Checked %0d results (%0d compare writes), %0d mismatches.",
                 results_seen, writes_seen, fail_count);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
